@@ rtl/billboard_quad_expander_macros.svh @@
// Assertion helpers for the billboard quad expander RTL.
`ifndef BILLBOARD_QUAD_EXPANDER_MACROS_SVH
`define BILLBOARD_QUAD_EXPANDER_MACROS_SVH
`ifndef ASSERT_OFF
`define BQE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");
`define BQE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");
`else
`define BQE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BQE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/bqe_pkg.sv @@
package bqe_pkg;

  localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;
  localparam logic [24:0] PRIO_STEP_Q30 = 25'd10737418;

  // Queue depths and count widths
  localparam int MQ_DEPTH = 8;
  localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [2:0] {
    REG_SPRITE_SCALE = 3'd0,
    REG_PIVOT_OFFSET = 3'd1,
    REG_BASIS_RIGHT  = 3'd2,
    REG_BASIS_UP     = 3'd3,
    REG_BASIS_VIEW   = 3'd4,
    REG_DEPTH_VECTOR = 3'd5,
    REG_PRIORITY     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] sprite_scale;
    logic        [31:0] pivot_offset;
    logic        [47:0] basis_right;
    logic        [47:0] basis_up;
    logic        [47:0] basis_view;
    logic        [47:0] depth_vector;
    logic signed [15:0] priority_cfg;
  } cfg_t;

  // One particle after the front end: rotated pivot and rotated half sizes
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] key;
    logic signed [53:0] tpx;
    logic signed [53:0] tpy;
    logic signed [48:0] chx;
    logic signed [48:0] shy;
    logic signed [48:0] shx;
    logic signed [48:0] chy;
    logic signed [33:0] zs;
    logic        [2:0]  rnd;
    logic        [2:0]  step;
  } mid_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] key;
    logic        [1:0]  corner;
    logic               last;
  } vtx_t;

  // Depth jitter along the view axis, Q.16
  localparam logic signed [13:0] JITTER [8] = '{
    14'sd1311, -14'sd3277, 14'sd4588, -14'sd7864,
    14'sd0, 14'sd1966, 14'sd5243, -14'sd2621
  };

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

@@ rtl/bqe_fifo.sv @@
module bqe_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

@@ rtl/bqe_front.sv @@
module bqe_front #(
  parameter int SINE_TABLE_SIZE = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bqe_pkg::cfg_t              cfg,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic signed [31:0]         in_position_x,
  input  logic signed [31:0]         in_position_y,
  input  logic signed [31:0]         in_position_z,
  input  logic signed [31:0]         in_rotation_angle,
  input  logic signed [15:0]         in_size_x,
  input  logic signed [15:0]         in_size_y,
  input  logic        [15:0]         in_particle_index,
  input  logic        [7:0]          in_frame_index,
  input  logic [bqe_pkg::MQ_CW-1:0]  mq_count,
  output logic                       mq_push,
  output bqe_pkg::mid_t              mq_data
);

  // Table size is a power of two; index wraps by truncation
  localparam int IW = $clog2(SINE_TABLE_SIZE);
  localparam longint unsigned KMUL =
    (longint'(SINE_TABLE_SIZE) << 44) / bqe_pkg::TWO_PI_Q28;
  localparam logic [IW-1:0] QUARTER = IW'(SINE_TABLE_SIZE / 4);

  typedef logic signed [15:0] sin_rom_t [SINE_TABLE_SIZE];

  // Shift-subtract quotient, used only while the table is built
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine in Q2.14 from a Taylor series, evaluated at elaboration
  function automatic sin_rom_t build_sin();
    sin_rom_t          tab;
    longint unsigned   mag;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    logic              neg;
    for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
      neg  = (k > SINE_TABLE_SIZE / 2);
      mag  = neg ? longint'(SINE_TABLE_SIZE - k) : longint'(k);
      x    = udiv64(mag * bqe_pkg::TWO_PI_Q28, 64'(SINE_TABLE_SIZE));
      x2   = (x * x) >> 28;
      term = x;
      sum  = longint'(x);
      for (int i = 1; i <= 9; i++) begin
        term = (term * x2) >> 28;
        term = udiv64(term, 64'((2 * i) * (2 * i + 1)));
        if (i[0]) sum = sum - longint'(term);
        else      sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 8192) >>> 14;
      if (sum > 16384) sum = 16384;
      tab[k] = neg ? 16'(-sum) : 16'(sum);
    end
    return tab;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin();
  localparam logic signed [63:0] KMUL_S = 64'(KMUL);

  logic        accept;
  logic [2:0]  inflight;

  // Stage 1: angle scaling, half sizes, depth products
  logic                s1_v_r;
  logic signed [63:0]  s1_a_r;
  logic signed [32:0]  s1_hx_r, s1_hy_r;
  logic        [33:0]  s1_zs_r;
  logic signed [47:0]  s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [40:0]  s1_pr_r;
  logic signed [31:0]  s1_px_r, s1_py_r, s1_pz_r;
  logic        [2:0]   s1_rnd_r, s1_step_r;

  // Stage 2: table reads, pivot products, depth key
  logic                s2_v_r;
  logic signed [15:0]  s2_sa_r, s2_sb_r, s2_ca_r, s2_cb_r;
  logic        [15:0]  s2_res_r;
  logic signed [48:0]  s2_pvpx_r, s2_pvpy_r;
  logic signed [31:0]  s2_key_r;
  logic signed [32:0]  s2_hx_r, s2_hy_r;
  logic        [33:0]  s2_zs_r;
  logic signed [31:0]  s2_px_r, s2_py_r, s2_pz_r;
  logic        [2:0]   s2_rnd_r, s2_step_r;

  // Stage 3: interpolated sine and cosine, pivot vector
  logic                s3_v_r;
  logic signed [15:0]  s3_s_r, s3_c_r;
  logic signed [36:0]  s3_pvx_r, s3_pvy_r;
  logic signed [31:0]  s3_key_r;
  logic signed [32:0]  s3_hx_r, s3_hy_r;
  logic        [33:0]  s3_zs_r;
  logic signed [31:0]  s3_px_r, s3_py_r, s3_pz_r;
  logic        [2:0]   s3_rnd_r, s3_step_r;

  // Stage 4: rotation products
  logic                s4_v_r;
  logic signed [52:0]  s4_cpvx_r, s4_spvy_r, s4_spvx_r, s4_cpvy_r;
  logic signed [48:0]  s4_chx_r, s4_shy_r, s4_shx_r, s4_chy_r;
  logic signed [31:0]  s4_key_r;
  logic        [33:0]  s4_zs_r;
  logic signed [31:0]  s4_px_r, s4_py_r, s4_pz_r;
  logic        [2:0]   s4_rnd_r, s4_step_r;

  // Hold off requests while the mid queue could not take every item in flight
  assign inflight = 3'(s1_v_r) + 3'(s2_v_r) + 3'(s3_v_r) + 3'(s4_v_r);
  assign in_full  = (5'(mq_count) + 5'(inflight)) >= 5'(bqe_pkg::MQ_DEPTH);
  assign accept   = in_push && !in_full;

  // Stage 1 operands
  logic signed [16:0] sx17, sy17;
  logic        [16:0] abs_sx, abs_sy, abs_sum;
  logic        [2:0]  seed_sq;

  assign sx17    = 17'(in_size_x);
  assign sy17    = 17'(in_size_y);
  assign abs_sx  = sx17[16] ? 17'(-sx17) : 17'(sx17);
  assign abs_sy  = sy17[16] ? 17'(-sy17) : 17'(sy17);
  assign abs_sum = abs_sx + abs_sy;
  assign seed_sq = 3'(in_particle_index[2:0] * in_particle_index[2:0]);

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    s1_a_r    <= 64'(in_rotation_angle) * KMUL_S;
    s1_hx_r   <= 33'(in_size_x) * $signed({17'b0, cfg.sprite_scale});
    s1_hy_r   <= 33'(in_size_y) * $signed({17'b0, cfg.sprite_scale});
    s1_zs_r   <= 34'(abs_sum) * 34'(cfg.sprite_scale);
    s1_dx_r   <= 48'(in_position_x) * 48'($signed(cfg.depth_vector[15:0]));
    s1_dy_r   <= 48'(in_position_y) * 48'($signed(cfg.depth_vector[31:16]));
    s1_dz_r   <= 48'(in_position_z) * 48'($signed(cfg.depth_vector[47:32]));
    s1_pr_r   <= 41'(cfg.priority_cfg) * $signed(41'(bqe_pkg::PRIO_STEP_Q30));
    s1_px_r   <= in_position_x;
    s1_py_r   <= in_position_y;
    s1_pz_r   <= in_position_z;
    s1_rnd_r  <= seed_sq + in_frame_index[2:0];
    s1_step_r <= in_particle_index[2:0] | 3'd1;
  end

  // Stage 2 operands
  logic [IW-1:0]       idx, idx_c;
  logic signed [50:0]  dsum;
  logic signed [50:0]  dsum_rnd;

  assign idx      = s1_a_r[32 +: IW];
  assign idx_c    = idx + QUARTER;
  assign dsum     = 51'(s1_dx_r) + 51'(s1_dy_r) + 51'(s1_dz_r) + 51'(s1_pr_r);
  assign dsum_rnd = (dsum + 51'sd8192) >>> 14;

  // Stage 2 payload
  always_ff @(posedge clk) begin
    s2_sa_r   <= SIN_ROM[idx];
    s2_sb_r   <= SIN_ROM[idx + IW'(1)];
    s2_ca_r   <= SIN_ROM[idx_c];
    s2_cb_r   <= SIN_ROM[idx_c + IW'(1)];
    s2_res_r  <= s1_a_r[31:16];
    s2_pvpx_r <= 49'(s1_hx_r) * 49'($signed(cfg.pivot_offset[15:0]));
    s2_pvpy_r <= 49'(s1_hy_r) * 49'($signed(cfg.pivot_offset[31:16]));
    s2_key_r  <= bqe_pkg::sat32(64'(dsum_rnd));
    s2_hx_r   <= s1_hx_r;
    s2_hy_r   <= s1_hy_r;
    s2_zs_r   <= s1_zs_r;
    s2_px_r   <= s1_px_r;
    s2_py_r   <= s1_py_r;
    s2_pz_r   <= s1_pz_r;
    s2_rnd_r  <= s1_rnd_r;
    s2_step_r <= s1_step_r;
  end

  // Stage 3 operands: linear interpolation and rounded pivot
  logic signed [16:0]  res_s;
  logic signed [34:0]  s_acc, c_acc;
  logic signed [48:0]  pvx_t, pvy_t;

  assign res_s = $signed({1'b0, s2_res_r});
  assign s_acc = (35'(s2_sa_r) <<< 16) + 35'((17'(s2_sb_r) - 17'(s2_sa_r)) * res_s)
                 + 35'sd32768;
  assign c_acc = (35'(s2_ca_r) <<< 16) + 35'((17'(s2_cb_r) - 17'(s2_ca_r)) * res_s)
                 + 35'sd32768;
  assign pvx_t = (s2_pvpx_r + 49'sd2048) >>> 12;
  assign pvy_t = (s2_pvpy_r + 49'sd2048) >>> 12;

  // Stage 3 payload
  always_ff @(posedge clk) begin
    s3_s_r    <= 16'(s_acc >>> 16);
    s3_c_r    <= 16'(c_acc >>> 16);
    s3_pvx_r  <= -(37'(pvx_t));
    s3_pvy_r  <= -(37'(pvy_t));
    s3_key_r  <= s2_key_r;
    s3_hx_r   <= s2_hx_r;
    s3_hy_r   <= s2_hy_r;
    s3_zs_r   <= s2_zs_r;
    s3_px_r   <= s2_px_r;
    s3_py_r   <= s2_py_r;
    s3_pz_r   <= s2_pz_r;
    s3_rnd_r  <= s2_rnd_r;
    s3_step_r <= s2_step_r;
  end

  // Stage 4 payload
  always_ff @(posedge clk) begin
    s4_cpvx_r <= 53'(s3_c_r) * 53'(s3_pvx_r);
    s4_spvy_r <= 53'(s3_s_r) * 53'(s3_pvy_r);
    s4_spvx_r <= 53'(s3_s_r) * 53'(s3_pvx_r);
    s4_cpvy_r <= 53'(s3_c_r) * 53'(s3_pvy_r);
    s4_chx_r  <= 49'(s3_c_r) * 49'(s3_hx_r);
    s4_shy_r  <= 49'(s3_s_r) * 49'(s3_hy_r);
    s4_shx_r  <= 49'(s3_s_r) * 49'(s3_hx_r);
    s4_chy_r  <= 49'(s3_c_r) * 49'(s3_hy_r);
    s4_key_r  <= s3_key_r;
    s4_zs_r   <= s3_zs_r;
    s4_px_r   <= s3_px_r;
    s4_py_r   <= s3_py_r;
    s4_pz_r   <= s3_pz_r;
    s4_rnd_r  <= s3_rnd_r;
    s4_step_r <= s3_step_r;
  end

  // Hand the particle to the mid queue
  assign mq_push      = s4_v_r;
  assign mq_data.pos_x = s4_px_r;
  assign mq_data.pos_y = s4_py_r;
  assign mq_data.pos_z = s4_pz_r;
  assign mq_data.key   = s4_key_r;
  assign mq_data.tpx   = 54'(s4_cpvx_r) - 54'(s4_spvy_r);
  assign mq_data.tpy   = 54'(s4_spvx_r) + 54'(s4_cpvy_r);
  assign mq_data.chx   = s4_chx_r;
  assign mq_data.shy   = s4_shy_r;
  assign mq_data.shx   = s4_shx_r;
  assign mq_data.chy   = s4_chy_r;
  assign mq_data.zs    = $signed(s4_zs_r);
  assign mq_data.rnd   = s4_rnd_r;
  assign mq_data.step  = s4_step_r;

endmodule

@@ rtl/bqe_back.sv @@
`include "billboard_quad_expander_macros.svh"

module bqe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  bqe_pkg::cfg_t cfg,
  input  logic          mq_empty,
  input  bqe_pkg::mid_t mq_data,
  output logic          mq_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output bqe_pkg::vtx_t out_vtx
);

  logic [1:0]                 cnt_r;
  logic [2:0]                 rnd_r;
  logic [2:0]                 rnd_cur;
  logic                       issue;
  logic [1:0]                 inflight;
  logic [bqe_pkg::OQ_CW-1:0]  oq_count;
  logic                       pos_x_sign, pos_y_sign;

  // Corner pipeline registers
  logic                b1_v_r;
  logic signed [41:0]  b1_lx_r, b1_ly_r;
  logic signed [47:0]  b1_jz_r;
  logic signed [31:0]  b1_px_r, b1_py_r, b1_pz_r, b1_key_r;
  logic [1:0]          b1_corner_r;

  logic                b2_v_r;
  logic signed [57:0]  b2_rx_r, b2_ry_r, b2_rz_r, b2_ux_r, b2_uy_r, b2_uz_r;
  logic signed [48:0]  b2_vx_r, b2_vy_r, b2_vz_r;
  logic signed [31:0]  b2_px_r, b2_py_r, b2_pz_r, b2_key_r;
  logic [1:0]          b2_corner_r;

  // Issue a corner only when the output queue has room for everything in flight
  assign inflight = 2'(b1_v_r) + 2'(b2_v_r);
  assign issue    = !mq_empty &&
                    ((4'(oq_count) + 4'(inflight)) < 4'(bqe_pkg::OQ_DEPTH));
  assign mq_pop   = issue && (cnt_r == 2'd3);
  assign rnd_cur  = (cnt_r == 2'd0) ? mq_data.rnd : rnd_r;

  // Corner signs: x positive on corners one and two, y on two and three
  assign pos_x_sign = (cnt_r == 2'd1) || (cnt_r == 2'd2);
  assign pos_y_sign = cnt_r[1];

  // Step through the four corners
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      rnd_r  <= 3'd0;
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      if (issue) begin
        cnt_r <= cnt_r + 2'd1;
        rnd_r <= rnd_cur + mq_data.step;
      end
      b1_v_r <= issue;
      b2_v_r <= b1_v_r;
    end
  end

  // Local corner in the sprite plane
  logic signed [55:0] sum_x, sum_y;
  logic signed [55:0] tx_chx, tx_shy, ty_shx, ty_chy;

  assign tx_chx = pos_x_sign ? 56'(mq_data.chx) : -56'(mq_data.chx);
  assign tx_shy = pos_y_sign ? 56'(mq_data.shy) : -56'(mq_data.shy);
  assign ty_shx = pos_x_sign ? 56'(mq_data.shx) : -56'(mq_data.shx);
  assign ty_chy = pos_y_sign ? 56'(mq_data.chy) : -56'(mq_data.chy);
  assign sum_x  = 56'(mq_data.tpx) + tx_chx - tx_shy + 56'sd8192;
  assign sum_y  = 56'(mq_data.tpy) + ty_shx + ty_chy + 56'sd8192;

  always_ff @(posedge clk) begin
    b1_lx_r     <= 42'(sum_x >>> 14);
    b1_ly_r     <= 42'(sum_y >>> 14);
    b1_jz_r     <= 48'(bqe_pkg::JITTER[rnd_cur]) * 48'(mq_data.zs);
    b1_px_r     <= mq_data.pos_x;
    b1_py_r     <= mq_data.pos_y;
    b1_pz_r     <= mq_data.pos_z;
    b1_key_r    <= mq_data.key;
    b1_corner_r <= cnt_r;
  end

  // Project onto the camera basis
  logic signed [47:0] jz_rnd;
  logic signed [32:0] dz;

  assign jz_rnd = (b1_jz_r + 48'sd32768) >>> 16;
  assign dz     = 33'(jz_rnd);

  always_ff @(posedge clk) begin
    b2_rx_r     <= 58'(b1_lx_r) * 58'($signed(cfg.basis_right[15:0]));
    b2_ry_r     <= 58'(b1_lx_r) * 58'($signed(cfg.basis_right[31:16]));
    b2_rz_r     <= 58'(b1_lx_r) * 58'($signed(cfg.basis_right[47:32]));
    b2_ux_r     <= 58'(b1_ly_r) * 58'($signed(cfg.basis_up[15:0]));
    b2_uy_r     <= 58'(b1_ly_r) * 58'($signed(cfg.basis_up[31:16]));
    b2_uz_r     <= 58'(b1_ly_r) * 58'($signed(cfg.basis_up[47:32]));
    b2_vx_r     <= 49'(dz) * 49'($signed(cfg.basis_view[15:0]));
    b2_vy_r     <= 49'(dz) * 49'($signed(cfg.basis_view[31:16]));
    b2_vz_r     <= 49'(dz) * 49'($signed(cfg.basis_view[47:32]));
    b2_px_r     <= b1_px_r;
    b2_py_r     <= b1_py_r;
    b2_pz_r     <= b1_pz_r;
    b2_key_r    <= b1_key_r;
    b2_corner_r <= b1_corner_r;
  end

  // Offset from the particle position, round and saturate
  logic signed [59:0] wx, wy, wz;
  logic signed [45:0] vx, vy, vz;
  bqe_pkg::vtx_t      vtx;

  assign wx = 60'(b2_rx_r) + 60'(b2_ux_r) + 60'(b2_vx_r) + 60'sd16384;
  assign wy = 60'(b2_ry_r) + 60'(b2_uy_r) + 60'(b2_vy_r) + 60'sd16384;
  assign wz = 60'(b2_rz_r) + 60'(b2_uz_r) + 60'(b2_vz_r) + 60'sd16384;
  assign vx = 46'(b2_px_r) + 46'(wx >>> 15);
  assign vy = 46'(b2_py_r) + 46'(wy >>> 15);
  assign vz = 46'(b2_pz_r) + 46'(wz >>> 15);

  assign vtx.vx     = bqe_pkg::sat32(64'(vx));
  assign vtx.vy     = bqe_pkg::sat32(64'(vy));
  assign vtx.vz     = bqe_pkg::sat32(64'(vz));
  assign vtx.key    = b2_key_r;
  assign vtx.corner = b2_corner_r;
  assign vtx.last   = (b2_corner_r == 2'd3);

  logic [$bits(bqe_pkg::vtx_t)-1:0] oq_rdata;

  bqe_fifo #(
    .DEPTH (bqe_pkg::OQ_DEPTH),
    .WIDTH ($bits(bqe_pkg::vtx_t))
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b2_v_r),
    .wdata (vtx),
    .pop   (out_pop && !out_empty),
    .rdata (oq_rdata),
    .count (oq_count)
  );

  assign out_empty = (oq_count == '0);
  assign out_vtx   = bqe_pkg::vtx_t'(oq_rdata);

  `BQE_ASSERT_IMP(a_oq_credit, clk, rst_n, 1'b1, (4'(oq_count) + 4'(inflight)) <= 4'(bqe_pkg::OQ_DEPTH))
  `BQE_ASSERT_NXT(a_corner_hold, clk, rst_n, !issue, cnt_r == $past(cnt_r))
  `BQE_ASSERT_NXT(a_b1_follows, clk, rst_n, issue, b1_v_r && (b1_corner_r == $past(cnt_r)))

endmodule

@@ rtl/billboard_quad_expander.sv @@
// Billboard quad expander: turns one particle into the four corner vertices
// of a rotated, pivoted, scaled camera-facing quad plus a shared depth key.
// Input queue port: present a particle with in_push while in_full is low.
// Result queue port: while out_empty is low the oldest vertex is on the out_
// ports; out_pop takes it. Corners come out in order 0..3, last_corner on 3.
// Config port: cfg_ready is always high; write registers only while idle.
// A particle's first vertex becomes visible once its accepted request has passed
// 4 front stages (angle scaling, sine table read, interpolation, rotation
// products), the write into the mid queue, 2 corner stages, then the write into
// the output queue. Throughput is one vertex per cycle while the mid queue holds
// a particle and the output queue has room; the corner sequencer in the back end
// issues each particle's four corners in turn.
// A stalled receiver fills the 4-entry output queue, then the 8-entry mid
// queue, then raises in_full; no result is dropped.
// Reset clears all queues and loads the register defaults (sprite_scale 256,
// everything else zero). The sine table is a constant ROM, no init pass.
module billboard_quad_expander #(
  parameter int SINE_TABLE_SIZE = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_position_x,
  input  logic signed [31:0] in_position_y,
  input  logic signed [31:0] in_position_z,
  input  logic signed [31:0] in_rotation_angle,
  input  logic signed [15:0] in_size_x,
  input  logic signed [15:0] in_size_y,
  input  logic        [15:0] in_particle_index,
  input  logic        [7:0]  in_frame_index,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_vertex_x,
  output logic signed [31:0] out_vertex_y,
  output logic signed [31:0] out_vertex_z,
  output logic signed [31:0] out_depth_key,
  output logic        [1:0]  out_corner,
  output logic               out_last_corner,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [47:0] cfg_data
);

  bqe_pkg::cfg_t cfg_r;

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sprite_scale <= 16'd256;
      cfg_r.pivot_offset <= '0;
      cfg_r.basis_right  <= '0;
      cfg_r.basis_up     <= '0;
      cfg_r.basis_view   <= '0;
      cfg_r.depth_vector <= '0;
      cfg_r.priority_cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bqe_pkg::reg_idx_t'(cfg_index))
        bqe_pkg::REG_SPRITE_SCALE: cfg_r.sprite_scale <= cfg_data[15:0];
        bqe_pkg::REG_PIVOT_OFFSET: cfg_r.pivot_offset <= cfg_data[31:0];
        bqe_pkg::REG_BASIS_RIGHT:  cfg_r.basis_right  <= cfg_data;
        bqe_pkg::REG_BASIS_UP:     cfg_r.basis_up     <= cfg_data;
        bqe_pkg::REG_BASIS_VIEW:   cfg_r.basis_view   <= cfg_data;
        bqe_pkg::REG_DEPTH_VECTOR: cfg_r.depth_vector <= cfg_data;
        bqe_pkg::REG_PRIORITY:     cfg_r.priority_cfg <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  logic                             mq_push;
  logic                             mq_pop;
  bqe_pkg::mid_t                    mq_wdata;
  logic [$bits(bqe_pkg::mid_t)-1:0] mq_rdata;
  logic [bqe_pkg::MQ_CW-1:0]        mq_count;
  bqe_pkg::vtx_t                    vtx;

  bqe_front #(
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_position_x     (in_position_x),
    .in_position_y     (in_position_y),
    .in_position_z     (in_position_z),
    .in_rotation_angle (in_rotation_angle),
    .in_size_x         (in_size_x),
    .in_size_y         (in_size_y),
    .in_particle_index (in_particle_index),
    .in_frame_index    (in_frame_index),
    .mq_count          (mq_count),
    .mq_push           (mq_push),
    .mq_data           (mq_wdata)
  );

  bqe_fifo #(
    .DEPTH (bqe_pkg::MQ_DEPTH),
    .WIDTH ($bits(bqe_pkg::mid_t))
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .count (mq_count)
  );

  bqe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mq_empty  (mq_count == '0),
    .mq_data   (bqe_pkg::mid_t'(mq_rdata)),
    .mq_pop    (mq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_vtx   (vtx)
  );

  assign out_vertex_x    = vtx.vx;
  assign out_vertex_y    = vtx.vy;
  assign out_vertex_z    = vtx.vz;
  assign out_depth_key   = vtx.key;
  assign out_corner      = vtx.corner;
  assign out_last_corner = vtx.last;

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_N = 512;
  localparam longint KMUL = longint'((64'd512 << 44) / bqe_pkg::TWO_PI_Q28);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] angle;
    logic signed [15:0] size_x;
    logic signed [15:0] size_y;
    logic        [15:0] pidx;
    logic        [7:0]  frame;
  } particle_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic signed [31:0] in_position_x;
  logic signed [31:0] in_position_y;
  logic signed [31:0] in_position_z;
  logic signed [31:0] in_rotation_angle;
  logic signed [15:0] in_size_x;
  logic signed [15:0] in_size_y;
  logic        [15:0] in_particle_index;
  logic        [7:0]  in_frame_index;
  logic               out_empty;
  logic               out_pop;
  logic signed [31:0] out_vertex_x;
  logic signed [31:0] out_vertex_y;
  logic signed [31:0] out_vertex_z;
  logic signed [31:0] out_depth_key;
  logic        [1:0]  out_corner;
  logic               out_last_corner;
  logic               cfg_valid;
  logic               cfg_ready;
  logic        [2:0]  cfg_index;
  logic        [47:0] cfg_data;

  billboard_quad_expander dut (.*);

  // Shadow copy of the register file
  logic        [15:0] sh_scale;
  logic        [31:0] sh_pivot;
  logic        [47:0] sh_right;
  logic        [47:0] sh_up;
  logic        [47:0] sh_view;
  logic        [47:0] sh_depth;
  logic signed [15:0] sh_prio;

  longint          sine_rom[TABLE_N];
  bqe_pkg::vtx_t   vertex_queue[$];
  int              mismatches;
  bit              rx_idle_en;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void build_sine_rom();
    longint unsigned mag, x, x2, term;
    longint sum;
    bit neg;
    for (int k = 0; k < TABLE_N; k++) begin
      neg = k > TABLE_N / 2;
      mag = neg ? 64'(TABLE_N - k) : 64'(k);
      x = mag * bqe_pkg::TWO_PI_Q28 / 64'(TABLE_N);
      x2 = (x * x) >> 28;
      term = x;
      sum = longint'(x);
      for (int i = 1; i <= 9; i++) begin
        term = (term * x2) >> 28;
        term = term / 64'((2 * i) * (2 * i + 1));
        if (i & 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 8192) >>> 14;
      if (sum > 16384) sum = 16384;
      sine_rom[k] = neg ? -sum : sum;
    end
  endfunction

  function automatic longint rnd_shift(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint part16(logic [47:0] vec, int i);
    return longint'($signed(vec[16*i +: 16]));
  endfunction

  function automatic longint lerp_sine(int idx, longint res);
    longint a, b;
    a = sine_rom[idx % TABLE_N];
    b = sine_rom[(idx + 1) % TABLE_N];
    return rnd_shift(a * 65536 + (b - a) * res, 16);
  endfunction

  // Expand one particle into its four corner vertices
  function automatic void expand_quad(particle_t p);
    longint pos[3];
    longint a, res, s, c, sc, sx, sy, hx, hy, pvx, pvy, tpx, tpy, zs, d, key;
    longint lx, ly, dz, w, cx, cy;
    longint jit[8];
    int idx;
    logic [2:0] rnd, stp;
    bqe_pkg::vtx_t v;
    jit = '{1311, -3277, 4588, -7864, 0, 1966, 5243, -2621};
    pos[0] = p.pos_x;
    pos[1] = p.pos_y;
    pos[2] = p.pos_z;
    sx = p.size_x;
    sy = p.size_y;
    a = longint'(p.angle) * KMUL;
    idx = int'(((a >>> 32) % TABLE_N + TABLE_N) % TABLE_N);
    res = (a & 64'hFFFFFFFF) >> 16;
    s = lerp_sine(idx, res);
    c = lerp_sine(idx + TABLE_N / 4, res);
    sc = longint'(sh_scale);
    hx = sx * sc;
    hy = sy * sc;
    pvx = -rnd_shift(hx * part16({16'h0, sh_pivot}, 0), 12);
    pvy = -rnd_shift(hy * part16({16'h0, sh_pivot}, 1), 12);
    tpx = c * pvx - s * pvy;
    tpy = s * pvx + c * pvy;
    zs = sc * ((sx < 0 ? -sx : sx) + (sy < 0 ? -sy : sy));
    d = 0;
    for (int ax = 0; ax < 3; ax++) d += pos[ax] * part16(sh_depth, ax);
    d += longint'(sh_prio) * longint'(bqe_pkg::PRIO_STEP_Q30);
    key = clamp32(rnd_shift(d, 14));
    rnd = p.pidx[2:0] * p.pidx[2:0] + p.frame[2:0];
    stp = p.pidx[2:0] | 3'd1;
    for (int k = 0; k < 4; k++) begin
      cx = (k == 1 || k == 2) ? 1 : -1;
      cy = (k >= 2) ? 1 : -1;
      lx = rnd_shift(tpx + cx * c * hx - cy * s * hy, 14);
      ly = rnd_shift(tpy + cx * s * hx + cy * c * hy, 14);
      dz = rnd_shift(jit[rnd] * zs, 16);
      w = lx * part16(sh_right, 0) + ly * part16(sh_up, 0) + dz * part16(sh_view, 0);
      v.vx = 32'(clamp32(pos[0] + rnd_shift(w, 15)));
      w = lx * part16(sh_right, 1) + ly * part16(sh_up, 1) + dz * part16(sh_view, 1);
      v.vy = 32'(clamp32(pos[1] + rnd_shift(w, 15)));
      w = lx * part16(sh_right, 2) + ly * part16(sh_up, 2) + dz * part16(sh_view, 2);
      v.vz = 32'(clamp32(pos[2] + rnd_shift(w, 15)));
      v.key = 32'(key);
      v.corner = 2'(k);
      v.last = (k == 3);
      vertex_queue.push_back(v);
      rnd = rnd + stp;
    end
  endfunction

  // Pop results with random stall bursts and compare against the oldest expectation
  initial begin : vertex_checker
    int stall_left;
    bqe_pkg::vtx_t exp_v;
    stall_left = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (vertex_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected vertex corner %0d", out_corner);
        end else begin
          exp_v = vertex_queue.pop_front();
          if (out_vertex_x !== exp_v.vx || out_vertex_y !== exp_v.vy ||
              out_vertex_z !== exp_v.vz || out_depth_key !== exp_v.key ||
              out_corner !== exp_v.corner || out_last_corner !== exp_v.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch exp x=%0d y=%0d z=%0d key=%0d c=%0d l=%0d",
                        " got x=%0d y=%0d z=%0d key=%0d c=%0d l=%0d"},
                       exp_v.vx, exp_v.vy, exp_v.vz, exp_v.key, exp_v.corner, exp_v.last,
                       out_vertex_x, out_vertex_y, out_vertex_z, out_depth_key,
                       out_corner, out_last_corner);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Send one particle request and record its expected vertices
  task automatic send_particle(particle_t p);
    in_push <= 1'b1;
    in_position_x <= p.pos_x;
    in_position_y <= p.pos_y;
    in_position_z <= p.pos_z;
    in_rotation_angle <= p.angle;
    in_size_x <= p.size_x;
    in_size_y <= p.size_y;
    in_particle_index <= p.pidx;
    in_frame_index <= p.frame;
    do @(posedge clk); while (in_full);
    expand_quad(p);
  endtask

  task automatic maybe_gap(bit idle_en);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(bqe_pkg::reg_idx_t idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bqe_pkg::REG_SPRITE_SCALE: sh_scale = val[15:0];
      bqe_pkg::REG_PIVOT_OFFSET: sh_pivot = val[31:0];
      bqe_pkg::REG_BASIS_RIGHT:  sh_right = val;
      bqe_pkg::REG_BASIS_UP:     sh_up = val;
      bqe_pkg::REG_BASIS_VIEW:   sh_view = val;
      bqe_pkg::REG_DEPTH_VECTOR: sh_depth = val;
      bqe_pkg::REG_PRIORITY:     sh_prio = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  function automatic particle_t rand_particle(bit tame);
    particle_t p;
    p = $bits(particle_t)'({$urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom()});
    if (tame) begin
      p.pos_x = $signed($urandom()) >>> 8;
      p.pos_y = $signed($urandom()) >>> 8;
      p.pos_z = $signed($urandom()) >>> 8;
      p.size_x = $signed(16'($urandom())) >>> 4;
      p.size_y = $signed(16'($urandom())) >>> 4;
    end
    return p;
  endfunction

  task automatic randomize_regs(bit extreme);
    write_reg(bqe_pkg::REG_SPRITE_SCALE,
              extreme ? ($urandom_range(0, 1) ? 48'hFFFF : 48'h0)
                      : 48'($urandom_range(0, 65535)));
    write_reg(bqe_pkg::REG_PIVOT_OFFSET, 48'($urandom()));
    write_reg(bqe_pkg::REG_BASIS_RIGHT, rand48());
    write_reg(bqe_pkg::REG_BASIS_UP, rand48());
    write_reg(bqe_pkg::REG_BASIS_VIEW, rand48());
    write_reg(bqe_pkg::REG_DEPTH_VECTOR, rand48());
    write_reg(bqe_pkg::REG_PRIORITY,
              extreme ? ($urandom_range(0, 1) ? 48'h7FFF : 48'h8000)
                      : 48'($urandom_range(0, 65535)));
  endtask

  // Reset values: only the sprite scale is nonzero, so vertices sit on the position
  task automatic test_reset_defaults();
    for (int i = 0; i < 6; i++) begin
      send_particle(rand_particle(0));
      maybe_gap(1);
    end
    drain();
  endtask

  // Field extremes under a unit-ish camera basis and extreme registers
  task automatic test_directed();
    particle_t p;
    write_reg(bqe_pkg::REG_SPRITE_SCALE, 48'h0100);
    write_reg(bqe_pkg::REG_PIVOT_OFFSET, 48'h0000_0800_F800);
    write_reg(bqe_pkg::REG_BASIS_RIGHT, {16'h0000, 16'h0000, 16'h4000});
    write_reg(bqe_pkg::REG_BASIS_UP, {16'h0000, 16'h4000, 16'h0000});
    write_reg(bqe_pkg::REG_BASIS_VIEW, {16'hC000, 16'h0000, 16'h0000});
    write_reg(bqe_pkg::REG_DEPTH_VECTOR, {16'h4000, 16'h0000, 16'h0000});
    write_reg(bqe_pkg::REG_PRIORITY, 48'h7FFF);
    p = '0;
    send_particle(p);
    p = '1;
    send_particle(p);
    p = {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
         16'h7FFF, 16'h7FFF, 16'hFFFF, 8'hFF};
    send_particle(p);
    p = {32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
         16'h8000, 16'h8000, 16'h0000, 8'h00};
    send_particle(p);
    // Quarter turn, half turn, small angles near zero from both sides
    p = {32'h0, 32'h0, 32'h0, 32'h0001_921F, 16'h0100, 16'h0200, 16'h0003, 8'h05};
    send_particle(p);
    p.angle = 32'h0003_243F;
    send_particle(p);
    p.angle = 32'hFFFF_FFFF;
    send_particle(p);
    p.angle = 32'h0000_0001;
    send_particle(p);
    drain();
    // Saturation of vertices and depth key
    write_reg(bqe_pkg::REG_BASIS_RIGHT, 48'h7FFF_7FFF_7FFF);
    write_reg(bqe_pkg::REG_BASIS_UP, 48'h8000_8000_8000);
    write_reg(bqe_pkg::REG_BASIS_VIEW, 48'h7FFF_8000_7FFF);
    write_reg(bqe_pkg::REG_DEPTH_VECTOR, 48'h7FFF_7FFF_7FFF);
    write_reg(bqe_pkg::REG_SPRITE_SCALE, 48'hFFFF);
    write_reg(bqe_pkg::REG_PRIORITY, 48'h8000);
    p = {32'h7FFF0000, 32'h80010000, 32'h7FFF0000, 32'h0000_C90F,
         16'h7FFF, 16'h8000, 16'h1234, 8'h80};
    send_particle(p);
    p.pos_x = 32'h80000000;
    p.pos_z = 32'h80000000;
    send_particle(p);
    drain();
    write_reg(bqe_pkg::REG_SPRITE_SCALE, 48'h0);
    write_reg(bqe_pkg::REG_PRIORITY, 48'h7FFF);
    send_particle(p);
    drain();
  endtask

  // Random particles across several register settings
  task automatic test_random_sweep(int settings, int per_setting);
    for (int s = 0; s < settings; s++) begin
      randomize_regs(s % 3 == 0);
      for (int i = 0; i < per_setting; i++) begin
        send_particle(rand_particle($urandom_range(0, 3) != 0));
        maybe_gap(1);
      end
      drain();
    end
  endtask

  // Fill up under receiver stalls, then hold the sender until all vertices are out
  task automatic test_pressure();
    for (int i = 0; i < 30; i++) send_particle(rand_particle(1));
    in_push <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    for (int i = 0; i < 10; i++) send_particle(rand_particle(0));
    drain();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate();
    rx_idle_en = 1'b0;
    for (int i = 0; i < 60; i++) send_particle(rand_particle($urandom_range(0, 1)));
    drain();
  endtask

  initial begin : main
    int guard;
    build_sine_rom();
    mismatches = 0;
    rx_idle_en = 1'b1;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_position_x = '0;
    in_position_y = '0;
    in_position_z = '0;
    in_rotation_angle = '0;
    in_size_x = '0;
    in_size_y = '0;
    in_particle_index = '0;
    in_frame_index = '0;
    cfg_valid = 1'b0;
    cfg_index = bqe_pkg::REG_SPRITE_SCALE;
    cfg_data = '0;
    sh_scale = 16'd256;
    sh_pivot = '0;
    sh_right = '0;
    sh_up = '0;
    sh_view = '0;
    sh_depth = '0;
    sh_prio = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_random_sweep(10, 30);
    test_pressure();
    test_full_rate();

    guard = 0;
    while (vertex_queue.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && vertex_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bqe_pkg.sv
rtl/bqe_fifo.sv
rtl/bqe_front.sv
rtl/bqe_back.sv
rtl/billboard_quad_expander.sv
dv/testbench.sv
